@@ rtl/lpi_pkg.sv @@
// ----------------------------------------------------------------------------
// Line-plane intersection package
// Shared widths, codes and payload types of the line-plane intersection unit.
// ----------------------------------------------------------------------------
package lpi_pkg;

    // Word format of every coordinate and coefficient.
    localparam int WORD_BITS = 32;
    // Exact product of two words.
    localparam int PROD_W    = 2 * WORD_BITS;
    // Sum of three products plus the offset term.
    localparam int SUM_W     = PROD_W + 2;
    // Limb width used to split the wide magnitude multiply.
    localparam int LIMB_W    = (SUM_W + 2) / 3;
    // Width of the direction-times-numerator magnitude and of the quotient.
    localparam int MAG_W     = WORD_BITS + SUM_W;
    // Width of the signed sum of point and quotient.
    localparam int ADD_W     = MAG_W + 2;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_PARALLEL  = 2'd1,
        STATUS_SATURATED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_COEF_A = 2'd0,
        REG_COEF_B = 2'd1,
        REG_COEF_C = 2'd2,
        REG_COEF_D = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] point_x;
        logic [WORD_BITS-1:0] point_y;
        logic [WORD_BITS-1:0] point_z;
        logic [WORD_BITS-1:0] dir_x;
        logic [WORD_BITS-1:0] dir_y;
        logic [WORD_BITS-1:0] dir_z;
    } line_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] hit_x;
        logic [WORD_BITS-1:0] hit_y;
        logic [WORD_BITS-1:0] hit_z;
        status_t              status;
    } hit_t;

    // Information that rides alongside the divider lanes.
    typedef struct packed {
        logic [2:0][WORD_BITS-1:0] point;
        logic [2:0]                neg;
        logic                      parallel;
    } div_side_t;

endpackage

@@ rtl/line_plane_intersection_unit.sv @@
// A line passes from transfer to hit through the 98-stage divider
// plus seven stages of products, sums, scaling and result assembly.
// Throughput: one line per cycle; the whole pipeline holds when the hit
// output is stalled, and a bubble in the output register frees it at once.
// Reset clears all valid bits and the plane coefficients to zero.
// ----------------------------------------------------------------------------
// Line-plane intersection unit
// Fixed-point intersection of a stream of lines with a configured plane.
// ----------------------------------------------------------------------------
module line_plane_intersection_unit
    import lpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 line_valid,
    output logic                 line_ready,
    input  line_t                line,
    output logic                 hit_valid,
    input  logic                 hit_ready,
    output hit_t                 hit,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data
);

    word_t                   coef_a_reg;
    word_t                   coef_b_reg;
    word_t                   coef_c_reg;
    word_t                   coef_d_reg;
    logic                    en;
    logic                    f_valid;
    logic signed [SUM_W-1:0] f_num;
    logic signed [SUM_W-1:0] f_den;
    word_t                   f_point [3];
    word_t                   f_dir [3];
    logic                    s_valid;
    logic [MAG_W-1:0]        s_mag [3];
    logic [SUM_W-1:0]        s_den;
    div_side_t               s_side;
    logic                    d_valid;
    logic [MAG_W-1:0]        d_quot [3];
    div_side_t               d_side;

    // The pipeline advances whenever the output register is free or drained.
    assign en         = !hit_valid || hit_ready;
    assign line_ready = en;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            coef_d_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COEF_A: coef_a_reg <= $signed(cfg_data);
                REG_COEF_B: coef_b_reg <= $signed(cfg_data);
                REG_COEF_C: coef_c_reg <= $signed(cfg_data);
                REG_COEF_D: coef_d_reg <= $signed(cfg_data);
                default:    coef_a_reg <= coef_a_reg;
            endcase
        end
    end

    lpi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (line_valid),
        .line      (line),
        .coef_a    (coef_a_reg),
        .coef_b    (coef_b_reg),
        .coef_c    (coef_c_reg),
        .coef_d    (coef_d_reg),
        .out_valid (f_valid),
        .num       (f_num),
        .den       (f_den),
        .point     (f_point),
        .dir       (f_dir)
    );

    lpi_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .point     (f_point),
        .dir       (f_dir),
        .out_valid (s_valid),
        .mag       (s_mag),
        .den_mag   (s_den),
        .side      (s_side)
    );

    lpi_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_valid),
        .dividend  (s_mag),
        .divisor   (s_den),
        .side_in   (s_side),
        .out_valid (d_valid),
        .quot      (d_quot),
        .side_out  (d_side)
    );

    lpi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .quot      (d_quot),
        .side      (d_side),
        .out_valid (hit_valid),
        .hit       (hit)
    );

endmodule

@@ rtl/lpi_front.sv @@
// ----------------------------------------------------------------------------
// Plane dot products
// Two stages: coefficient products, then the numerator and denominator sums.
// ----------------------------------------------------------------------------
module lpi_front
    import lpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  line_t                   line,
    input  word_t                   coef_a,
    input  word_t                   coef_b,
    input  word_t                   coef_c,
    input  word_t                   coef_d,
    output logic                    out_valid,
    output logic signed [SUM_W-1:0] num,
    output logic signed [SUM_W-1:0] den,
    output word_t                   point [3],
    output word_t                   dir [3]
);

    word_t                    co [3];
    word_t                    pt_in [3];
    word_t                    dir_in [3];
    logic signed [PROD_W-1:0] pnum_reg [3];
    logic signed [PROD_W-1:0] pden_reg [3];
    word_t                    pt1_reg [3];
    word_t                    dir1_reg [3];
    word_t                    pt2_reg [3];
    word_t                    dir2_reg [3];
    logic signed [SUM_W-1:0]  num_reg;
    logic signed [SUM_W-1:0]  den_reg;
    logic                     vld1_reg;
    logic                     vld2_reg;

    assign co[0]     = coef_a;
    assign co[1]     = coef_b;
    assign co[2]     = coef_c;
    assign pt_in[0]  = $signed(line.point_x);
    assign pt_in[1]  = $signed(line.point_y);
    assign pt_in[2]  = $signed(line.point_z);
    assign dir_in[0] = $signed(line.dir_x);
    assign dir_in[1] = $signed(line.dir_y);
    assign dir_in[2] = $signed(line.dir_z);

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
        end
    end

    // Stage one forms the six exact products; stage two sums them.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pnum_reg[i] <= co[i] * pt_in[i];
                pden_reg[i] <= co[i] * dir_in[i];
                pt1_reg[i]  <= pt_in[i];
                dir1_reg[i] <= dir_in[i];
                pt2_reg[i]  <= pt1_reg[i];
                dir2_reg[i] <= dir1_reg[i];
            end
            num_reg <= SUM_W'(pnum_reg[0]) + SUM_W'(pnum_reg[1]) + SUM_W'(pnum_reg[2])
                     + (SUM_W'(coef_d) <<< FRAC_BITS);
            den_reg <= SUM_W'(pden_reg[0]) + SUM_W'(pden_reg[1]) + SUM_W'(pden_reg[2]);
        end
    end

    assign out_valid = vld2_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign point     = pt2_reg;
    assign dir       = dir2_reg;

endmodule

@@ rtl/lpi_scale.sv @@
// ----------------------------------------------------------------------------
// Magnitude scaling
// Three stages: absolute values and signs, limb products, limb sum.
// ----------------------------------------------------------------------------
module lpi_scale
    import lpi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [SUM_W-1:0] num,
    input  logic signed [SUM_W-1:0] den,
    input  word_t                   point [3],
    input  word_t                   dir [3],
    output logic                    out_valid,
    output logic [MAG_W-1:0]        mag [3],
    output logic [SUM_W-1:0]        den_mag,
    output div_side_t               side
);

    localparam int PP_W  = WORD_BITS + LIMB_W;
    localparam int PAD_W = 3 * LIMB_W;

    logic [WORD_BITS-1:0] adir_reg [3];
    logic [SUM_W-1:0]     anum_reg;
    logic [SUM_W-1:0]     aden3_reg;
    logic [SUM_W-1:0]     aden4_reg;
    logic [SUM_W-1:0]     aden5_reg;
    logic [PAD_W-1:0]     anum_pad;
    logic [PP_W-1:0]      pp_reg [3][3];
    logic [MAG_W-1:0]     mag_reg [3];
    div_side_t            side3_reg;
    div_side_t            side4_reg;
    div_side_t            side5_reg;
    logic [2:0]           vld_reg;
    logic                 num_neg;
    logic                 den_neg;
    div_side_t            side_next;

    assign num_neg  = num[SUM_W-1];
    assign den_neg  = den[SUM_W-1];
    assign anum_pad = PAD_W'(anum_reg);

    // Quotient sign per axis; the quotient is the negated ratio.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            side_next.point[i] = point[i];
            side_next.neg[i]   = ~(dir[i][WORD_BITS-1] ^ num_neg ^ den_neg);
        end
        side_next.parallel = (den == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Absolute values.
            anum_reg  <= num_neg ? SUM_W'(-num) : SUM_W'(num);
            aden3_reg <= den_neg ? SUM_W'(-den) : SUM_W'(den);
            for (int i = 0; i < 3; i++)
            begin
                adir_reg[i] <= dir[i][WORD_BITS-1] ? WORD_BITS'(-dir[i])
                                                   : WORD_BITS'(dir[i]);
            end
            side3_reg <= side_next;

            // Limb products of direction and numerator magnitudes.
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pp_reg[i][k] <= adir_reg[i] * anum_pad[k*LIMB_W +: LIMB_W];
                end
            end
            aden4_reg <= aden3_reg;
            side4_reg <= side3_reg;

            // Recombine the limbs.
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= MAG_W'(pp_reg[i][0])
                            + (MAG_W'(pp_reg[i][1]) << LIMB_W)
                            + (MAG_W'(pp_reg[i][2]) << (2 * LIMB_W));
            end
            aden5_reg <= aden4_reg;
            side5_reg <= side4_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign mag       = mag_reg;
    assign den_mag   = aden5_reg;
    assign side      = side5_reg;

endmodule

@@ rtl/lpi_divider.sv @@
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division, one quotient bit per stage, three lanes sharing a divisor.
// ----------------------------------------------------------------------------
module lpi_divider
    import lpi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [MAG_W-1:0] dividend [3],
    input  logic [SUM_W-1:0] divisor,
    input  div_side_t        side_in,
    output logic             out_valid,
    output logic [MAG_W-1:0] quot [3],
    output div_side_t        side_out
);

    localparam int N = MAG_W;

    // Each stage holds the partial remainder and the dividend bits still to
    // shift in, with quotient bits entering at the bottom.
    logic [MAG_W-1:0] nq_reg [N][3];
    logic [SUM_W-1:0] rem_reg [N][3];
    logic [SUM_W-1:0] dvs_reg [N];
    div_side_t        side_reg [N];
    logic [N-1:0]     vld_reg;

    logic [MAG_W-1:0] nq_src [N][3];
    logic [SUM_W-1:0] rem_src [N][3];
    logic [SUM_W-1:0] dvs_src [N];
    div_side_t        side_src [N];
    logic [N-1:0]     vld_src;
    logic [MAG_W-1:0] nq_next [N][3];
    logic [SUM_W-1:0] rem_next [N][3];

    // Stage inputs.
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            nq_src[0][l]  = dividend[l];
            rem_src[0][l] = '0;
        end
        dvs_src[0]  = divisor;
        side_src[0] = side_in;
        vld_src[0]  = in_valid;
        for (int s = 1; s < N; s++)
        begin
            nq_src[s]   = nq_reg[s-1];
            rem_src[s]  = rem_reg[s-1];
            dvs_src[s]  = dvs_reg[s-1];
            side_src[s] = side_reg[s-1];
            vld_src[s]  = vld_reg[s-1];
        end
    end

    // One trial subtraction per stage and lane.
    always_comb
    begin
        logic [SUM_W:0] trial;
        logic [SUM_W:0] diff;
        logic           ge;
        for (int s = 0; s < N; s++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial = {rem_src[s][l], nq_src[s][l][MAG_W-1]};
                diff  = trial - {1'b0, dvs_src[s]};
                ge    = (trial >= {1'b0, dvs_src[s]});
                rem_next[s][l] = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
                nq_next[s][l]  = {nq_src[s][l][MAG_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_src;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_reg   <= nq_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_src;
            side_reg <= side_src;
        end
    end

    assign out_valid = vld_reg[N-1];
    assign quot      = nq_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

@@ rtl/lpi_back.sv @@
// ----------------------------------------------------------------------------
// Result assembly
// Adds the signed quotient to the start point, saturates and holds the result.
// ----------------------------------------------------------------------------
module lpi_back
    import lpi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [MAG_W-1:0] quot [3],
    input  div_side_t        side,
    output logic             out_valid,
    output hit_t             hit
);

    logic signed [ADD_W-1:0] sum_reg [3];
    logic                    par_reg;
    logic                    vld_reg;
    logic                    hit_valid_reg;
    hit_t                    hit_reg;
    hit_t                    hit_next;
    logic [WORD_BITS-1:0]    coord [3];
    logic [2:0]              clamp;

    // Point plus or minus the quotient magnitude.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (side.neg[i])
                begin
                    sum_reg[i] <= ADD_W'($signed(side.point[i])) - $signed({2'b00, quot[i]});
                end
                else
                begin
                    sum_reg[i] <= ADD_W'($signed(side.point[i])) + $signed({2'b00, quot[i]});
                end
            end
            par_reg <= side.parallel;
        end
    end

    // Saturation to the word range.
    always_comb
    begin
        logic [ADD_W-WORD_BITS:0] upper;
        for (int i = 0; i < 3; i++)
        begin
            upper    = sum_reg[i][ADD_W-1:WORD_BITS-1];
            clamp[i] = (upper != '0) && (upper != '1);
            if (!clamp[i])
            begin
                coord[i] = sum_reg[i][WORD_BITS-1:0];
            end
            else if (sum_reg[i][ADD_W-1])
            begin
                coord[i] = {1'b1, {(WORD_BITS-1){1'b0}}};
            end
            else
            begin
                coord[i] = {1'b0, {(WORD_BITS-1){1'b1}}};
            end
        end
        if (par_reg)
        begin
            hit_next.hit_x  = '0;
            hit_next.hit_y  = '0;
            hit_next.hit_z  = '0;
            hit_next.status = STATUS_PARALLEL;
        end
        else
        begin
            hit_next.hit_x  = coord[0];
            hit_next.hit_y  = coord[1];
            hit_next.hit_z  = coord[2];
            hit_next.status = (clamp != '0) ? STATUS_SATURATED : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= 1'b0;
            hit_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= in_valid;
            hit_valid_reg <= vld_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
        end
    end

    assign out_valid = hit_valid_reg;
    assign hit       = hit_reg;

endmodule
